@@ rtl/assert_macros.svh @@
// Assertion macros shared by the divider search RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define SCDS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("scds assertion failed");

// Clocked assertion that also holds during reset.
`define SCDS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("scds assertion failed");

`endif

@@ rtl/scds_pkg.sv @@
// Shared types and constants of the serial clock divider search.
package scds_pkg;

  localparam int DATA_W     = 32;
  localparam int DIV_W      = 16;
  localparam int PRE_W      = 9;
  localparam int FAC_W      = 8;
  localparam int STATUS_W   = 2;
  localparam int PRESCALE_W = 8;
  localparam int ACHIEVED_W = 31;

  localparam int PRESCALE_MIN_DEF = 2;
  localparam int PRESCALE_MAX_DEF = 254;
  localparam int FACTOR_MAX_DEF   = 255;
  localparam int PRESCALE_STEP    = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND    = 2'd0,
    ST_TOO_FAST = 2'd1,
    ST_TOO_SLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DIV_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ rtl/scds_ifs.sv @@
// Channel interfaces: request, result and bus clock configuration.
interface scds_req_if import scds_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] requested_hz;
  modport source (output valid, output requested_hz, input ready);
  modport sink   (input valid, input requested_hz, output ready);
endinterface

interface scds_res_if import scds_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [PRESCALE_W-1:0] prescale;
  logic [FAC_W-1:0]      rate_factor;
  logic [ACHIEVED_W-1:0] achieved_hz;
  modport source (output valid, output status, output prescale, output rate_factor,
                  output achieved_hz, input ready);
  modport sink   (input valid, input status, input prescale, input rate_factor,
                  input achieved_hz, output ready);
endinterface

interface scds_cfg_if import scds_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/scds_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
module scds_div import scds_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DATA_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dvs;
  logic [DATA_W-1:0] dq;

  logic [DIV_W:0]    trial;
  logic              qbit;
  logic [DIV_W-1:0]  rem_next;

  always_comb begin
    trial    = {rem, dq[DATA_W-1]};
    qbit     = (trial >= {1'b0, dvs});
    rem_next = qbit ? DIV_W'(trial - {1'b0, dvs}) : trial[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dq   <= req.dividend;
        dvs  <= req.divisor;
      end else if (busy) begin
        rem <= rem_next;
        dq  <= {dq[DATA_W-2:0], qbit};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = dq;

endmodule

@@ rtl/spi_clock_divider_search.sv @@
// Top level: sequencer that searches divider pairs through one shared divider.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   requested_hz[31:0]
//   res      out  valid/ready   status[1:0] prescale[7:0] rate_factor[7:0] achieved_hz[30:0]
//   cfg      in   valid/ready   data[31:0] (bus_clock_hz)
//
// Each rate takes a multiply (S_MUL), a divider start (S_START), the division (S_WAIT), which
// also hands over the quotient, and an evaluation (S_EVAL). An item costs two range checks and
// then up to 127 prescales times 256 factors, each run through the one shared divider.
// Synchronous reset clears the sequencer, the output valid and the bus clock register.
// req is not ready during a search; a finished result waits for a free output register.
`include "assert_macros.svh"

module spi_clock_divider_search import scds_pkg::*; #(
  parameter int PRESCALE_MIN = PRESCALE_MIN_DEF,
  parameter int PRESCALE_MAX = PRESCALE_MAX_DEF,
  parameter int FACTOR_MAX   = FACTOR_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  scds_req_if.sink   req,
  scds_res_if.source res,
  scds_cfg_if.sink   cfg
);

  localparam logic [PRE_W-1:0] PRE_MIN  = PRE_W'(PRESCALE_MIN);
  localparam logic [PRE_W-1:0] PRE_MAX  = PRE_W'(PRESCALE_MAX);
  localparam logic [PRE_W-1:0] PRE_STEP = PRE_W'(PRESCALE_STEP);
  localparam logic [FAC_W-1:0] FAC_MAX  = FAC_W'(FACTOR_MAX);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_START, S_WAIT, S_EVAL, S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    PH_FAST, PH_SLOW, PH_SEARCH
  } phase_t;

  state_t            state;
  phase_t            phase;
  logic [DATA_W-1:0] bus_clock_hz;
  logic [DATA_W-1:0] req_hz;
  logic [PRE_W-1:0]  pre;
  logic [FAC_W-1:0]  fac;
  logic [DIV_W-1:0]  divisor;
  logic [DATA_W-1:0] rate;
  logic [DATA_W-1:0] best_rate;
  logic [PRE_W-1:0]  best_pre;
  logic [FAC_W-1:0]  best_fac;
  logic              have;
  status_t           fin_status;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic [PRE_W-1:0]  pre_next;
  logic [PRE_W:0]    fac_plus;
  logic              take;

  always_comb begin
    pre_next = pre + PRE_STEP;
    fac_plus = {{(PRE_W + 1 - FAC_W){1'b0}}, fac} + 1'b1;
    take     = !have || (rate > best_rate);
  end

  assign div_req.start    = (state == S_START);
  assign div_req.dividend = bus_clock_hz;
  assign div_req.divisor  = divisor;

  scds_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_FAST;
      bus_clock_hz <= '0;
      have         <= 1'b0;
      res.valid    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        bus_clock_hz <= cfg.data;
      end
      if (res.valid && res.ready && state != S_FINISH) begin
        res.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            req_hz     <= req.requested_hz;
            phase      <= PH_FAST;
            pre        <= PRE_MIN;
            fac        <= '0;
            have       <= 1'b0;
            best_rate  <= '0;
            best_pre   <= '0;
            best_fac   <= '0;
            fin_status <= ST_FOUND;
            state      <= S_MUL;
          end
        end
        S_MUL: begin
          divisor <= DIV_W'(pre) * DIV_W'(fac_plus);
          state   <= S_START;
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_rsp.done) begin
            rate  <= div_rsp.quotient;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          case (phase)
            PH_FAST: begin
              if (req_hz > rate) begin
                fin_status <= ST_TOO_FAST;
                state      <= S_FINISH;
              end else begin
                phase <= PH_SLOW;
                pre   <= PRE_MAX;
                fac   <= FAC_MAX;
                state <= S_MUL;
              end
            end
            PH_SLOW: begin
              if (req_hz < rate) begin
                fin_status <= ST_TOO_SLOW;
                state      <= S_FINISH;
              end else begin
                phase <= PH_SEARCH;
                pre   <= PRE_MIN;
                fac   <= '0;
                state <= S_MUL;
              end
            end
            default: begin
              if (rate > req_hz && fac != FAC_MAX) begin
                fac   <= fac + 1'b1;
                state <= S_MUL;
              end else begin
                if (rate <= req_hz && take) begin
                  have      <= 1'b1;
                  best_rate <= rate;
                  best_pre  <= pre;
                  best_fac  <= fac;
                end
                if ((rate <= req_hz && take && rate == req_hz) || pre_next > PRE_MAX) begin
                  state <= S_FINISH;
                end else begin
                  pre   <= pre_next;
                  fac   <= '0;
                  state <= S_MUL;
                end
              end
            end
          endcase
        end
        S_FINISH: begin
          if (!res.valid || res.ready) begin
            res.valid       <= 1'b1;
            res.status      <= fin_status;
            res.prescale    <= best_pre[PRESCALE_W-1:0];
            res.rate_factor <= best_fac;
            res.achieved_hz <= best_rate[ACHIEVED_W-1:0];
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SCDS_ASSERT(a_best_le_req, clk, rst, (have |-> best_rate <= req_hz))
  `SCDS_ASSERT(a_found_has_pair, clk, rst,
    ((res.valid && res.status == ST_FOUND && $rose(res.valid)) |-> res.prescale != '0))
  `SCDS_ASSERT(a_error_zero, clk, rst,
    ((res.valid && res.status != ST_FOUND) |-> (res.prescale == '0 && res.achieved_hz == '0)))
  `SCDS_ASSERT(a_rise_from_finish, clk, rst, ($rose(res.valid) |-> $past(state) == S_FINISH))
  `SCDS_ASSERT(a_div_start_idle, clk, rst, (div_req.start |-> !div_rsp.busy))

endmodule

@@ dv/scds_tb_pkg.sv @@
// Scoreboard package for the serial clock divider search: expected divider choices and checks.
`timescale 1ns / 1ps

package scds_tb_pkg;
  import scds_pkg::*;

  typedef struct packed {
    status_t               status;
    logic [PRESCALE_W-1:0] prescale;
    logic [FAC_W-1:0]      rate_factor;
    logic [ACHIEVED_W-1:0] achieved_hz;
  } divider_choice_t;

  class divider_checker;
    logic [DATA_W-1:0] bus_clock_hz;
    divider_choice_t   owed[$];
    int unsigned       mismatches;

    function new();
      bus_clock_hz = '0;
      mismatches   = 0;
    endfunction

    function divider_choice_t best_divider(input logic [DATA_W-1:0] hz,
                                           output int unsigned evals);
      divider_choice_t   pick;
      logic [DATA_W-1:0] rate;
      logic [DATA_W-1:0] best_rate;
      bit                have;
      bit                hit;
      pick      = '{ST_FOUND, '0, '0, '0};
      best_rate = '0;
      have      = 1'b0;
      hit       = 1'b0;
      evals     = 0;
      if (hz > bus_clock_hz / 32'(PRESCALE_MIN_DEF)) begin
        pick.status = ST_TOO_FAST;
        return pick;
      end
      if (hz < bus_clock_hz / 32'(PRESCALE_MAX_DEF * (FACTOR_MAX_DEF + 1))) begin
        pick.status = ST_TOO_SLOW;
        return pick;
      end
      for (int pre = PRESCALE_MIN_DEF; pre <= PRESCALE_MAX_DEF && !hit;
           pre += PRESCALE_STEP) begin
        for (int fac = 0; fac <= FACTOR_MAX_DEF; fac++) begin
          evals++;
          rate = bus_clock_hz / 32'(pre * (fac + 1));
          if (rate <= hz) begin
            if (!have || rate > best_rate) begin
              have             = 1'b1;
              best_rate        = rate;
              pick.prescale    = PRESCALE_W'(pre);
              pick.rate_factor = FAC_W'(fac);
              hit              = (rate == hz);
            end
            break;
          end
        end
      end
      pick.achieved_hz = best_rate[ACHIEVED_W-1:0];
      return pick;
    endfunction

    function void note_request(input logic [DATA_W-1:0] hz);
      int unsigned evals;
      owed.push_back(best_divider(hz, evals));
    endfunction

    function void check_result(input divider_choice_t got);
      divider_choice_t want;
      if (owed.size() == 0) begin
        $error("result with no request outstanding: status %0d prescale %0d",
               got.status, got.prescale);
        mismatches++;
        return;
      end
      want = owed.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.prescale !== want.prescale) begin
        $error("prescale: expected %0d, got %0d", want.prescale, got.prescale);
        mismatches++;
      end
      if (got.rate_factor !== want.rate_factor) begin
        $error("rate_factor: expected %0d, got %0d", want.rate_factor, got.rate_factor);
        mismatches++;
      end
      if (got.achieved_hz !== want.achieved_hz) begin
        $error("achieved_hz: expected %0d, got %0d", want.achieved_hz, got.achieved_hz);
        mismatches++;
      end
    endfunction
  endclass

endpackage

@@ dv/spi_clock_divider_search_tb.sv @@
// Top testbench of the serial clock divider search: drives requests and bus clock writes.
`timescale 1ns / 1ps

module spi_clock_divider_search_tb;
  import scds_pkg::*;
  import scds_tb_pkg::*;

  localparam int STALL_LIMIT  = 5_000_000;
  localparam int EVAL_BUDGET  = 300;
  localparam int DRAIN_CYCLES = 100;

  logic           clk = 1'b0;
  logic           rst;
  bit             calm = 1'b0;
  int unsigned    stall_cycles = 0;
  divider_checker sb;

  scds_req_if req_if ();
  scds_res_if res_if ();
  scds_cfg_if cfg_if ();

  spi_clock_divider_search u_top (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .res(res_if),
    .cfg(cfg_if)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (calm) begin
      res_if.ready <= 1'b1;
    end else begin
      res_if.ready <= ($urandom_range(99) >= 38);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      sb.check_result(divider_choice_t'{status_t'(res_if.status), res_if.prescale,
                                        res_if.rate_factor, res_if.achieved_hz});
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("spi_clock_divider_search_tb NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_request(input logic [DATA_W-1:0] hz);
    while (!calm && $urandom_range(99) < 38) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.requested_hz <= hz;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(hz);
  endtask

  task automatic set_bus_clock(input logic [DATA_W-1:0] hz);
    req_if.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= hz;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid    <= 1'b0;
    sb.bus_clock_hz = hz;
  endtask

  task automatic run_random(input int count);
    logic [DATA_W-1:0] fastest;
    logic [DATA_W-1:0] slowest;
    logic [DATA_W-1:0] hz;
    int unsigned       evals;
    int                tries;
    fastest = sb.bus_clock_hz / 32'(PRESCALE_MIN_DEF);
    slowest = sb.bus_clock_hz / 32'(PRESCALE_MAX_DEF * (FACTOR_MAX_DEF + 1));
    repeat (count) begin
      tries = 0;
      do begin
        case ($urandom_range(9))
          0: hz = $urandom;
          1: hz = $urandom_range(1) ? fastest + $urandom_range(1) : slowest - $urandom_range(1);
          2, 3, 4, 5: hz = $urandom_range(fastest, slowest);
          6, 7: hz = sb.bus_clock_hz / (2 * $urandom_range(1, 127) * $urandom_range(1, 16));
          default: hz = fastest >> $urandom_range(16);
        endcase
        void'(sb.best_divider(hz, evals));
        tries++;
      end while (evals > EVAL_BUDGET && tries < 8);
      if (evals > EVAL_BUDGET) begin
        hz = fastest;
      end
      send_request(hz);
    end
  endtask

  initial begin
    sb = new();
    rst                 <= 1'b1;
    req_if.valid        <= 1'b0;
    req_if.requested_hz <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.data         <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // bus clock still at its reset value
    send_request(32'd0);
    send_request(32'd1);
    send_request(32'hFFFF_FFFF);

    set_bus_clock(32'hFFFF_FFFF);
    send_request(32'd0);
    send_request(32'd66051);
    send_request(32'd66052);
    send_request(32'h7FFF_FFFF);
    send_request(32'h8000_0000);
    send_request(32'hFFFF_FFFF);
    send_request(32'd1_000_000_000);
    send_request(32'd715_827_882);
    run_random(20);

    set_bus_clock(32'd0);
    send_request(32'd0);
    send_request(32'd5);
    run_random(4);

    set_bus_clock(32'd1000);
    send_request(32'd0);
    send_request(32'd500);
    send_request(32'd501);
    send_request(32'd7);
    run_random(12);

    set_bus_clock(32'd48_000_000);
    calm = 1'b1;
    send_request(32'd24_000_000);
    send_request(32'd24_000_001);
    send_request(32'd1_000_000);
    send_request(32'd400_000);
    run_random(20);
    calm = 1'b0;

    for (int i = 0; i < 3; i++) begin
      set_bus_clock(i == 0 ? 32'($urandom_range(200_000)) : 32'($urandom));
      run_random(14);
    end

    req_if.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("spi_clock_divider_search_tb OK");
    end else begin
      $display("spi_clock_divider_search_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/scds_pkg.sv
rtl/scds_ifs.sv
rtl/scds_div.sv
rtl/spi_clock_divider_search.sv
dv/scds_tb_pkg.sv
dv/spi_clock_divider_search_tb.sv
